// ===== rtl/tbvb_pkg.sv =====
// ---------------------------------------------------------------------------
// tbvb_pkg: shared types and constants
// Operation codes, fixed-point angle constants, float constants and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package tbvb_pkg;

   // Angles are degrees with 16 fraction bits.
   localparam logic [24:0] DEG_90  = 25'd5898240;
   localparam logic [24:0] DEG_180 = 25'd11796480;
   localparam logic [24:0] DEG_270 = 25'd17694720;
   localparam logic [24:0] DEG_360 = 25'd23592960;

   localparam logic [4:0] MAX_DEPTH = 5'd16;

   // Single-precision constants.
   localparam logic [31:0] FP_ZERO         = 32'h0000_0000;
   localparam logic [31:0] FP_ONE          = 32'h3f80_0000;
   localparam logic [31:0] FP_NEG_ONE      = 32'hbf80_0000;
   localparam logic [31:0] FP_HALF         = 32'h3f00_0000;
   localparam logic [31:0] FP_THREE_HALVES = 32'h3fc0_0000;
   localparam logic [31:0] ISQRT_MAGIC     = 32'h5f37_59df;

   typedef logic [3:0] op_type;

   // Floating-point operations, in issue order within one bisection.
   localparam op_type OP_SX   = 4'd0;   // sx = ux + lx
   localparam op_type OP_SY   = 4'd1;   // sy = uy + ly
   localparam op_type OP_SQX  = 4'd2;   // t = sx * sx
   localparam op_type OP_SQY  = 4'd3;   // q = sy * sy
   localparam op_type OP_SUM  = 4'd4;   // v = t + q
   localparam op_type OP_SEED = 4'd5;   // half = v * 0.5, g = seed
   localparam op_type OP_HG   = 4'd6;   // t = half * g
   localparam op_type OP_HGG  = 4'd7;   // t = t * g
   localparam op_type OP_CORR = 4'd8;   // t = 1.5 - t
   localparam op_type OP_NEWG = 4'd9;   // g = g * t
   localparam op_type OP_NX   = 4'd10;  // nx = sx * g
   localparam op_type OP_NY   = 4'd11;  // ny = sy * g
   localparam op_type OP_C1   = 4'd12;  // t = px * ny
   localparam op_type OP_C2   = 4'd13;  // q = py * nx
   localparam op_type OP_CR   = 4'd14;  // t = t - q
   localparam op_type OP_DIV  = 4'd15;  // quot = py / px

   typedef struct packed {
      logic   red_load;
      logic   red_step;
      logic   red_fix;
      logic   init;
      logic   start;
      op_type op;
      logic   step;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic       red_last;
      logic       axis;
      logic       done;
      logic       first;
      logic       hit;
      logic       px_zero;
      logic [4:0] iters;
   } stat_type;

endpackage

// ===== rtl/tangent_by_vector_bisection_top.sv =====
// ---------------------------------------------------------------------------
// tangent_by_vector_bisection_top: tangent of a fixed-point angle
// One item is in work at a time.
// Synchronous active-high reset clears the controller and output valid.
// ---------------------------------------------------------------------------
module tangent_by_vector_bisection_top
   import tbvb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle_deg
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] tangent_bits, [36:32] iterations_used,
                                    // [61:37] reached_angle, [63:62] zero
   output logic [1:0]  rsp_tuser,   // [0] undefined_flag, [1] exact_hit
   // Configuration writes: index 0 is bisection_depth, 1 is precision_mode.
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata
);

   // Every float operation is issued alone on a two-stage adder or multiplier;
   // the final slope uses a 26-step divider. The next item is taken while a
   // finished result waits on the output register. Reset also sets the depth
   // register to 10 and the precision register to 1.

   // The controller owns both handshakes and the configuration registers; the
   // datapath owns all arithmetic and the output payload register.
   cmd_type     cmd;
   stat_type    stat;
   logic [31:0] tangent_bits;
   logic        undefined_flag;
   logic        exact_hit;
   logic [4:0]  iterations_used;
   logic [24:0] reached_angle;

   tbvb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   tbvb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .angle_deg       (req_tdata),
      .cmd             (cmd),
      .stat            (stat),
      .tangent_bits    (tangent_bits),
      .undefined_flag  (undefined_flag),
      .exact_hit       (exact_hit),
      .iterations_used (iterations_used),
      .reached_angle   (reached_angle)
   );

   // The payload stays in place while a result waits, since the datapath only
   // reloads it when the controller sees the output register free.
   assign rsp_tdata = {2'b00, reached_angle, iterations_used, tangent_bits};
   assign rsp_tuser = {exact_hit, undefined_flag};

endmodule

// ===== rtl/tbvb_fpadd.sv =====
// ---------------------------------------------------------------------------
// tbvb_fpadd: two-stage single-precision adder
// Stage one aligns and adds, stage two normalizes and rounds to nearest even.
// ---------------------------------------------------------------------------
module tbvb_fpadd
   import tbvb_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] sum
);

   logic        swap;
   logic [31:0] big, sml;
   logic [7:0]  dexp;
   logic [26:0] mbig, msml_full, msml, mask;
   logic        sticky;
   logic        sub;
   logic        pass_in, sign_in;
   logic [31:0] pass_val_in;
   logic [27:0] raw_in;

   logic        pass_ff, sign_ff;
   logic [31:0] pass_val_ff;
   logic [7:0]  exp_ff;
   logic [27:0] raw_ff;

   always_comb begin
      swap      = op_b[30:0] > op_a[30:0];
      big       = swap ? op_b : op_a;
      sml       = swap ? op_a : op_b;
      dexp      = big[30:23] - sml[30:23];
      mbig      = {1'b1, big[22:0], 3'b000};
      msml_full = {1'b1, sml[22:0], 3'b000};
      mask      = '0;
      msml      = '0;
      sticky    = 1'b1;
      if (dexp <= 8'd26) begin
         msml   = msml_full >> dexp;
         mask   = (27'd1 << dexp) - 27'd1;
         sticky = |(msml_full & mask);
      end
      msml    = {msml[26:1], msml[0] | sticky};
      sub     = big[31] ^ sml[31];
      raw_in  = sub ? ({1'b0, mbig} - {1'b0, msml}) : ({1'b0, mbig} + {1'b0, msml});
      sign_in = big[31];
      // A zero operand passes the other one through; two zeros give the
      // round-to-nearest sign rule.
      pass_in     = (sml[30:23] == 8'd0);
      pass_val_in = (big[30:23] == 8'd0) ? {op_a[31] & op_b[31], 31'd0} : big;
   end

   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      pass_val_ff <= pass_val_in;
      sign_ff     <= sign_in;
      exp_ff      <= big[30:23];
      raw_ff      <= raw_in;
   end

   logic [4:0]  lz;
   logic        found;
   logic [26:0] norm;
   logic [8:0]  e;
   logic        up;
   logic [24:0] mr;
   logic [31:0] sum_in;
   logic [31:0] sum_ff;

   always_comb begin
      lz    = 5'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && raw_ff[i]) begin
            lz    = 5'(26 - i);
            found = 1'b1;
         end
      end
      if (raw_ff[27]) begin
         norm = {raw_ff[27:2], raw_ff[1] | raw_ff[0]};
         e    = {1'b0, exp_ff} + 9'd1;
      end else begin
         norm = raw_ff[26:0] << lz;
         e    = {1'b0, exp_ff} - {4'd0, lz};
      end
      up = norm[2] & (norm[1] | norm[0] | norm[3]);
      mr = {1'b0, norm[26:3]} + {24'd0, up};
      if (mr[24]) begin
         e = e + 9'd1;
      end
      if (pass_ff) begin
         sum_in = pass_val_ff;
      end else if (raw_ff == 28'd0) begin
         sum_in = FP_ZERO;
      end else begin
         sum_in = {sign_ff, e[7:0], mr[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/tbvb_fpmul.sv =====
// ---------------------------------------------------------------------------
// tbvb_fpmul: two-stage single-precision multiplier
// Stage one forms the 24 by 24 product, stage two normalizes and rounds.
// ---------------------------------------------------------------------------
module tbvb_fpmul
   import tbvb_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] prod
);

   logic [47:0] p_ff;
   logic [9:0]  e_ff;
   logic        zero_ff, sign_ff;

   always_ff @(posedge clock) begin
      p_ff    <= {1'b1, op_a[22:0]} * {1'b1, op_b[22:0]};
      e_ff    <= {2'b00, op_a[30:23]} + {2'b00, op_b[30:23]};
      zero_ff <= (op_a[30:23] == 8'd0) || (op_b[30:23] == 8'd0);
      sign_ff <= op_a[31] ^ op_b[31];
   end

   logic [23:0] m;
   logic        g, st, up;
   logic [9:0]  e;
   logic [24:0] mr;
   logic [31:0] prod_in;
   logic [31:0] prod_ff;

   always_comb begin
      if (p_ff[47]) begin
         m  = p_ff[47:24];
         g  = p_ff[23];
         st = |p_ff[22:0];
         e  = e_ff - 10'd126;
      end else begin
         m  = p_ff[46:23];
         g  = p_ff[22];
         st = |p_ff[21:0];
         e  = e_ff - 10'd127;
      end
      up = g & (st | m[0]);
      mr = {1'b0, m} + {24'd0, up};
      if (mr[24]) begin
         e = e + 10'd1;
      end
      prod_in = zero_ff ? {sign_ff, 31'd0} : {sign_ff, e[7:0], mr[22:0]};
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/tbvb_fpdiv.sv =====
// ---------------------------------------------------------------------------
// tbvb_fpdiv: iterative single-precision divider
// Restoring division, one quotient bit per cycle, then a rounding step.
// ---------------------------------------------------------------------------
module tbvb_fpdiv
   import tbvb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic [31:0] quot,
   output logic        done
);

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [24:0] rem_ff;
   logic [23:0] mden_ff;
   logic [25:0] q_ff;
   logic [9:0]  e_ff;
   logic        sign_ff, zero_ff;
   logic [31:0] quot_ff;

   logic [23:0] mnum, mden;
   logic [9:0]  e0;
   logic        ge;
   logic [24:0] rem_d;
   logic        up;
   logic [24:0] mr;
   logic [9:0]  ef;

   always_comb begin
      mnum  = {1'b1, num[22:0]};
      mden  = {1'b1, den[22:0]};
      e0    = {2'b00, num[30:23]} - {2'b00, den[30:23]} + 10'd127;
      ge    = rem_ff >= {1'b0, mden_ff};
      rem_d = ge ? (rem_ff - {1'b0, mden_ff}) : rem_ff;
      up    = q_ff[1] & (q_ff[0] | (rem_ff != 25'd0) | q_ff[2]);
      mr    = {1'b0, q_ff[25:2]} + {24'd0, up};
      ef    = mr[24] ? (e_ff + 10'd1) : e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= 5'd26;
         mden_ff <= mden;
         q_ff    <= '0;
         sign_ff <= num[31] ^ den[31];
         zero_ff <= (num[30:23] == 8'd0);
         if (mnum < mden) begin
            rem_ff <= {mnum, 1'b0};
            e_ff   <= e0 - 10'd1;
         end else begin
            rem_ff <= {1'b0, mnum};
            e_ff   <= e0;
         end
      end else if (busy_ff && cnt_ff != 5'd0) begin
         cnt_ff <= cnt_ff - 5'd1;
         q_ff   <= {q_ff[24:0], ge};
         rem_ff <= {rem_d[23:0], 1'b0};
      end else if (busy_ff) begin
         quot_ff <= zero_ff ? {sign_ff, 31'd0} : {sign_ff, ef[7:0], mr[22:0]};
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

// ===== rtl/tbvb_datapath.sv =====
// ---------------------------------------------------------------------------
// tbvb_datapath: angle reduction, vector registers and float units
// Holds the bisection vectors, the tracked angle and the result register,
// and runs one float operation at a time on the shared units.
// ---------------------------------------------------------------------------
module tbvb_datapath
   import tbvb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] angle_deg,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic [31:0] tangent_bits,
   output logic        undefined_flag,
   output logic        exact_hit,
   output logic [4:0]  iterations_used,
   output logic [24:0] reached_angle
);

   // Angle reduction: subtract 360 degrees shifted down from 64 times.
   logic [31:0] m_ff;
   logic        neg_ff;
   logic [2:0]  red_k_ff;
   logic [24:0] r_ff;
   logic [31:0] sub_val;

   assign sub_val = {7'd0, DEG_360} << red_k_ff;

   always_ff @(posedge clock) begin
      if (cmd.red_load) begin
         neg_ff   <= angle_deg[31];
         m_ff     <= angle_deg[31] ? (32'd0 - angle_deg) : angle_deg;
         red_k_ff <= 3'd6;
      end else if (cmd.red_step) begin
         if (m_ff >= sub_val) begin
            m_ff <= m_ff - sub_val;
         end
         red_k_ff <= red_k_ff - 3'd1;
      end
      if (cmd.red_fix) begin
         r_ff <= (neg_ff && m_ff != 32'd0) ? (DEG_360 - m_ff[24:0]) : m_ff[24:0];
      end
   end

   logic is0, is90, is180, is270, axis;
   assign is0   = (r_ff == 25'd0);
   assign is90  = (r_ff == DEG_90);
   assign is180 = (r_ff == DEG_180);
   assign is270 = (r_ff == DEG_270);
   assign axis  = is0 | is90 | is180 | is270;

   // Float registers.
   logic [31:0] ux_ff, uy_ff, lx_ff, ly_ff, sx_ff, sy_ff, t_ff, q_ff, v_ff;
   logic [31:0] half_ff, g_ff, nx_ff, ny_ff, px_ff, py_ff, quot_ff;
   logic [24:0] cur_ff, cut_ff;
   logic [4:0]  iters_ff;
   logic        first_ff, hit_ff;

   // Operation sequencing on the shared units.
   op_type      op_ff;
   logic        busy_ff;
   logic [1:0]  cnt_ff;
   logic        is_add, is_div, done;
   logic [31:0] add_a, add_b, mul_a, mul_b, add_res, mul_res, div_res, res;
   logic        div_done;

   assign is_div = (op_ff == OP_DIV);
   assign is_add = (op_ff == OP_SX) || (op_ff == OP_SY) || (op_ff == OP_SUM) ||
                   (op_ff == OP_CORR) || (op_ff == OP_CR);
   assign done   = busy_ff && (is_div ? div_done : (cnt_ff == 2'd2));
   assign res    = is_div ? div_res : (is_add ? add_res : mul_res);

   always_comb begin
      add_a = ux_ff;
      add_b = lx_ff;
      unique case (op_ff)
         OP_SY: begin
            add_a = uy_ff;
            add_b = ly_ff;
         end
         OP_SUM: begin
            add_a = t_ff;
            add_b = q_ff;
         end
         OP_CORR: begin
            add_a = FP_THREE_HALVES;
            add_b = {~t_ff[31], t_ff[30:0]};
         end
         OP_CR: begin
            add_a = t_ff;
            add_b = {~q_ff[31], q_ff[30:0]};
         end
         default: begin
            add_a = ux_ff;
            add_b = lx_ff;
         end
      endcase
   end

   always_comb begin
      mul_a = sx_ff;
      mul_b = sx_ff;
      unique case (op_ff)
         OP_SQY: begin
            mul_a = sy_ff;
            mul_b = sy_ff;
         end
         OP_SEED: begin
            mul_a = v_ff;
            mul_b = FP_HALF;
         end
         OP_HG: begin
            mul_a = half_ff;
            mul_b = g_ff;
         end
         OP_HGG: begin
            mul_a = t_ff;
            mul_b = g_ff;
         end
         OP_NEWG: begin
            mul_a = g_ff;
            mul_b = t_ff;
         end
         OP_NX: begin
            mul_a = sx_ff;
            mul_b = g_ff;
         end
         OP_NY: begin
            mul_a = sy_ff;
            mul_b = g_ff;
         end
         OP_C1: begin
            mul_a = px_ff;
            mul_b = ny_ff;
         end
         OP_C2: begin
            mul_a = py_ff;
            mul_b = nx_ff;
         end
         default: begin
            mul_a = sx_ff;
            mul_b = sx_ff;
         end
      endcase
   end

   tbvb_fpadd u_add (
      .clock (clock),
      .op_a  (add_a),
      .op_b  (add_b),
      .sum   (add_res)
   );

   tbvb_fpmul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_res)
   );

   tbvb_fpdiv u_div (
      .clock (clock),
      .reset (reset),
      .start (busy_ff && is_div && cnt_ff == 2'd0),
      .num   (py_ff),
      .den   (px_ff),
      .quot  (div_res),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 2'd0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && cnt_ff != 2'd2) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff <= cmd.op;
      end
   end

   // Bisection step: the direction follows the sign of the cross product.
   logic        dir;
   logic [24:0] cut_n, cur_n;
   assign dir   = !first_ff && !t_ff[31] && (t_ff[30:23] != 8'd0);
   assign cut_n = {1'b0, cut_ff[24:1]};
   assign cur_n = dir ? (cur_ff + cut_n) : (cur_ff - cut_n);

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         iters_ff <= 5'd0;
         first_ff <= 1'b1;
         cut_ff   <= DEG_90;
         px_ff    <= FP_ZERO;
         py_ff    <= FP_ZERO;
         if (r_ff < DEG_90) begin
            ux_ff <= FP_ZERO;    uy_ff <= FP_ONE;
            lx_ff <= FP_ONE;     ly_ff <= FP_ZERO;
            cur_ff <= DEG_90;
         end else if (r_ff < DEG_180) begin
            ux_ff <= FP_NEG_ONE; uy_ff <= FP_ZERO;
            lx_ff <= FP_ZERO;    ly_ff <= FP_ONE;
            cur_ff <= DEG_180;
         end else if (r_ff < DEG_270) begin
            ux_ff <= FP_ZERO;    uy_ff <= FP_NEG_ONE;
            lx_ff <= FP_NEG_ONE; ly_ff <= FP_ZERO;
            cur_ff <= DEG_270;
         end else begin
            ux_ff <= FP_ONE;     uy_ff <= FP_ZERO;
            lx_ff <= FP_ZERO;    ly_ff <= FP_NEG_ONE;
            cur_ff <= DEG_360;
         end
      end else if (cmd.step) begin
         cut_ff   <= cut_n;
         cur_ff   <= cur_n;
         hit_ff   <= (r_ff == cur_n);
         iters_ff <= iters_ff + 5'd1;
         first_ff <= 1'b0;
         px_ff    <= nx_ff;
         py_ff    <= ny_ff;
         if (r_ff > cur_n) begin
            lx_ff <= nx_ff;
            ly_ff <= ny_ff;
         end else begin
            ux_ff <= nx_ff;
            uy_ff <= ny_ff;
         end
      end
      if (done) begin
         unique case (op_ff) inside
            OP_SX:   sx_ff <= res;
            OP_SY:   sy_ff <= res;
            OP_SQX, OP_HG, OP_HGG, OP_CORR, OP_C1, OP_CR: t_ff <= res;
            OP_SQY, OP_C2: q_ff <= res;
            OP_SUM:  v_ff <= res;
            OP_SEED: begin
               half_ff <= res;
               g_ff    <= ISQRT_MAGIC - {1'b0, v_ff[31:1]};
            end
            OP_NEWG: g_ff  <= res;
            OP_NX:   nx_ff <= res;
            OP_NY:   ny_ff <= res;
            OP_DIV:  quot_ff <= res;
            default: ;
         endcase
      end
   end

   // Result register.
   logic px_zero;
   assign px_zero = (px_ff[30:23] == 8'd0);

   logic [31:0] tan_ff;
   logic        undef_ff, hit_out_ff;
   logic [4:0]  iters_out_ff;
   logic [24:0] reached_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         tan_ff       <= (axis || px_zero) ? FP_ZERO : quot_ff;
         undef_ff     <= is90 | is270;
         hit_out_ff   <= !axis && hit_ff;
         iters_out_ff <= axis ? 5'd0 : iters_ff;
         reached_ff   <= axis ? r_ff : cur_ff;
      end
   end

   assign tangent_bits    = tan_ff;
   assign undefined_flag  = undef_ff;
   assign exact_hit       = hit_out_ff;
   assign iterations_used = iters_out_ff;
   assign reached_angle   = reached_ff;

   always_comb begin
      stat          = '0;
      stat.red_last = (red_k_ff == 3'd0);
      stat.axis     = axis;
      stat.done     = done;
      stat.first    = first_ff;
      stat.hit      = hit_ff;
      stat.px_zero  = px_zero;
      stat.iters    = iters_ff;
   end

endmodule

// ===== rtl/tbvb_ctrl.sv =====
// ---------------------------------------------------------------------------
// tbvb_ctrl: sequencing state machine and configuration registers
// Issues reduction steps and float operations to the datapath and handles
// both handshakes.
// ---------------------------------------------------------------------------
module tbvb_ctrl
   import tbvb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic       csr_wen,
   input  logic       csr_addr,
   input  logic [4:0] csr_wdata,
   output cmd_type    cmd,
   input  stat_type   stat
);

   localparam logic REG_DEPTH     = 1'b0;
   localparam logic REG_PRECISION = 1'b1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RED   = 4'd1;
   localparam logic [3:0] S_FIX   = 4'd2;
   localparam logic [3:0] S_CLASS = 4'd3;
   localparam logic [3:0] S_ISSUE = 4'd4;
   localparam logic [3:0] S_WAIT  = 4'd5;
   localparam logic [3:0] S_STEP  = 4'd6;
   localparam logic [3:0] S_CHECK = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   logic [3:0] state_ff, state_in;
   op_type     op_ff, op_in;
   logic       pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] depth_ff;
   logic       prec_ff;
   logic [4:0] depth_eff;

   always_comb begin
      if (depth_ff == 5'd0) begin
         depth_eff = 5'd1;
      end else if (depth_ff > MAX_DEPTH) begin
         depth_eff = MAX_DEPTH;
      end else begin
         depth_eff = depth_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.red_load = 1'b1;
               state_in     = S_RED;
            end
         end
         S_RED: begin
            cmd.red_step = 1'b1;
            if (stat.red_last) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.red_fix = 1'b1;
            state_in    = S_CLASS;
         end
         S_CLASS: begin
            if (stat.axis) begin
               state_in = S_FIN;
            end else begin
               cmd.init = 1'b1;
               op_in    = OP_SX;
               pass_in  = 1'b0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (stat.done) begin
               state_in = S_ISSUE;
               case (op_ff)
                  OP_NEWG: begin
                     if (prec_ff && !pass_ff) begin
                        pass_in = 1'b1;
                        op_in   = OP_HG;
                     end else begin
                        op_in = OP_NX;
                     end
                  end
                  OP_NY: begin
                     if (stat.first) begin
                        state_in = S_STEP;
                     end else begin
                        op_in = OP_C1;
                     end
                  end
                  OP_CR:   state_in = S_STEP;
                  OP_DIV:  state_in = S_FIN;
                  default: op_in = op_ff + 4'd1;
               endcase
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            pass_in  = 1'b0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_ISSUE;
            if (stat.hit || stat.iters == depth_eff) begin
               if (stat.px_zero) begin
                  state_in = S_FIN;
               end else begin
                  op_in = OP_DIV;
               end
            end else begin
               op_in = OP_SX;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_SX;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= 5'd10;
         prec_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_addr)
               REG_DEPTH:     depth_ff <= csr_wdata;
               REG_PRECISION: prec_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/tbvb_checker.sv =====
// ---------------------------------------------------------------------------
// tbvb_checker: port-level assertions
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
module tbvb_checker
   import tbvb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[31:0] == 32'd0 && rsp_tdata[36:32] == 5'd0 && !rsp_tuser[1])
      else $error("undefined result carries data");

   a_iters_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:32] <= MAX_DEPTH && rsp_tdata[61:37] <= DEG_360)
      else $error("iteration count or angle out of range");

   a_hit_iters: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[36:32] != 5'd0)
      else $error("exact hit without bisection");

endmodule

bind tangent_by_vector_bisection_top tbvb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
